// ===== rtl/spla_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the surface pool allocator.
// No dependencies; every other file in rtl uses it.
package spla_pkg;

    localparam int DEF_MAX_SURFACES = 32;
    localparam int DEF_AGE_BITS     = 32;

    localparam int CFG_W  = 6;
    localparam int CMD_W  = 3;
    localparam int SIDX_W = 5;
    localparam int REF_W  = 4;

    localparam logic [REF_W-1:0] REF_MAX   = 4'd15;
    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_HOLD    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FLUSH   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESET   = 3'd4;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ALLOC,
        OP_RELEASE,
        OP_HOLD,
        OP_FLUSH,
        OP_CLEAR
    } cell_op_t;

endpackage

// ===== rtl/surface_pool_lru_allocator.sv =====
`timescale 1ns / 1ps
// Surface pool allocator top: command sequencer, config register and the cell row.
// Depends on spla_pkg and spla_cell.
// Allocate gives its registered result once the search token, walking the cell row one cell per cycle,
// has passed every cell; no new beat is accepted during the scan. Release, hold, flush, pool reset
// and spare codes give their result in the next cycle, one beat per cycle while out_ready does not stall.
// rst_n clears all counts and stamps, sets the age counter to one and the surface count to 32.
module surface_pool_lru_allocator #(
    parameter int MAX_SURFACES = spla_pkg::DEF_MAX_SURFACES,
    parameter int AGE_BITS     = spla_pkg::DEF_AGE_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [spla_pkg::CMD_W-1:0]  cmd,
    input  logic [spla_pkg::SIDX_W-1:0] surface_index,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [spla_pkg::SIDX_W-1:0] granted_surface,
    output logic                        forced_reuse,
    output logic                        status,
    input  logic                        cfg_we,
    input  logic [spla_pkg::CFG_W-1:0]  cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_SURFACES);
    localparam int N_W   = $clog2(MAX_SURFACES + 1);
    localparam int CMP_W = (N_W > spla_pkg::CFG_W) ? N_W : spla_pkg::CFG_W;
    localparam int CNT_W = $clog2(MAX_SURFACES + 1);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                       state_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [spla_pkg::CFG_W-1:0]   cfg_reg;
    logic [AGE_BITS-1:0]          next_age_reg;
    logic                         out_valid_reg;
    logic [spla_pkg::SIDX_W-1:0]  granted_reg;
    logic                         forced_reg;
    logic                         status_reg;

    logic [N_W-1:0]               count;
    logic [CMP_W-1:0]             cfg_ext;
    logic                         accept;
    logic                         out_of_range;
    logic                         commit;
    logic                         result_load;
    spla_pkg::cell_op_t           op;
    logic [IDX_W-1:0]             target;
    logic [IDX_W-1:0]             pick;

    logic                         tok_free_found [MAX_SURFACES+1];
    logic [IDX_W-1:0]             tok_free_idx   [MAX_SURFACES+1];
    logic [AGE_BITS-1:0]          tok_free_age   [MAX_SURFACES+1];
    logic [IDX_W-1:0]             tok_any_idx    [MAX_SURFACES+1];
    logic [AGE_BITS-1:0]          tok_any_age    [MAX_SURFACES+1];

    assign cfg_ext = CMP_W'(cfg_reg);
    assign count   = (cfg_reg == '0) ? N_W'(1)
                   : (cfg_ext > CMP_W'(MAX_SURFACES)) ? N_W'(MAX_SURFACES)
                   : N_W'(cfg_ext);

    assign in_ready     = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept       = in_valid && in_ready;
    assign out_of_range = CMP_W'(surface_index) >= CMP_W'(count);
    assign commit       = (state_reg == ST_SCAN) && (cnt_reg == CNT_W'(MAX_SURFACES));
    assign result_load  = commit || (accept && cmd != spla_pkg::CMD_ALLOC);

    assign pick = tok_free_found[MAX_SURFACES] ? tok_free_idx[MAX_SURFACES]
                                               : tok_any_idx[MAX_SURFACES];

    always_comb
    begin
        op     = spla_pkg::OP_NONE;
        target = IDX_W'(surface_index);
        if (commit)
        begin
            op     = spla_pkg::OP_ALLOC;
            target = pick;
        end
        else if (accept)
        begin
            priority case (1'b1)
                cmd == spla_pkg::CMD_RELEASE && !out_of_range: op = spla_pkg::OP_RELEASE;
                cmd == spla_pkg::CMD_HOLD && !out_of_range:    op = spla_pkg::OP_HOLD;
                cmd == spla_pkg::CMD_FLUSH:                    op = spla_pkg::OP_FLUSH;
                cmd == spla_pkg::CMD_RESET:                    op = spla_pkg::OP_CLEAR;
                default:                                       op = spla_pkg::OP_NONE;
            endcase
        end
    end

    assign tok_free_found[0] = 1'b0;
    assign tok_free_idx[0]   = '0;
    assign tok_free_age[0]   = '0;
    assign tok_any_idx[0]    = '0;
    assign tok_any_age[0]    = '1;

    for (genvar g = 0; g < MAX_SURFACES; g++)
    begin : g_cell
        spla_cell #(
            .MAX_SURFACES (MAX_SURFACES),
            .AGE_BITS     (AGE_BITS),
            .INDEX        (g)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .op             (op),
            .target         (target),
            .wr_age         (next_age_reg),
            .count          (count),
            .free_found_in  (tok_free_found[g]),
            .free_idx_in    (tok_free_idx[g]),
            .free_age_in    (tok_free_age[g]),
            .any_idx_in     (tok_any_idx[g]),
            .any_age_in     (tok_any_age[g]),
            .free_found_out (tok_free_found[g+1]),
            .free_idx_out   (tok_free_idx[g+1]),
            .free_age_out   (tok_free_age[g+1]),
            .any_idx_out    (tok_any_idx[g+1]),
            .any_age_out    (tok_any_age[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            cfg_reg       <= spla_pkg::CFG_RESET;
            next_age_reg  <= AGE_BITS'(1);
            out_valid_reg <= 1'b0;
            granted_reg   <= '0;
            forced_reg    <= 1'b0;
            status_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cfg_reg <= cfg_wdata;
            if (result_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (cmd == spla_pkg::CMD_ALLOC)
                        begin
                            state_reg <= ST_SCAN;
                            cnt_reg   <= '0;
                        end
                        else
                        begin
                            granted_reg   <= surface_index;
                            forced_reg    <= 1'b0;
                            status_reg    <= (cmd == spla_pkg::CMD_RELEASE ||
                                              cmd == spla_pkg::CMD_HOLD) && out_of_range;
                        end
                    end
                end
                ST_SCAN:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (commit)
                    begin
                        state_reg     <= ST_IDLE;
                        granted_reg   <= spla_pkg::SIDX_W'(pick);
                        forced_reg    <= !tok_free_found[MAX_SURFACES];
                        status_reg    <= 1'b0;
                        if (next_age_reg != '1)
                            next_age_reg <= next_age_reg + AGE_BITS'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign granted_surface = granted_reg;
    assign forced_reuse    = forced_reg;
    assign status          = status_reg;

    a_alloc_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == spla_pkg::CMD_ALLOC) |=> (state_reg == ST_SCAN && !out_valid_reg))
        else $error("allocate beat did not start a scan");

    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (out_valid_reg && state_reg == ST_IDLE && !status_reg))
        else $error("scan end did not produce a result");

    a_maint_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd != spla_pkg::CMD_ALLOC) |=> (out_valid_reg && !forced_reg))
        else $error("maintenance beat did not produce a plain result");

    a_age_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_age_reg != '0)
        else $error("age counter wrapped to zero");

endmodule

// ===== rtl/spla_cell.sv =====
`timescale 1ns / 1ps
// One pool cell: reference count and age stamp of one surface, plus one stage
// of the search token that moves down the row. Depends on spla_pkg.
module spla_cell #(
    parameter int MAX_SURFACES = spla_pkg::DEF_MAX_SURFACES,
    parameter int AGE_BITS     = spla_pkg::DEF_AGE_BITS,
    parameter int INDEX        = 0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  spla_pkg::cell_op_t              op,
    input  logic [$clog2(MAX_SURFACES)-1:0] target,
    input  logic [AGE_BITS-1:0]             wr_age,
    input  logic [$clog2(MAX_SURFACES+1)-1:0] count,
    input  logic                            free_found_in,
    input  logic [$clog2(MAX_SURFACES)-1:0] free_idx_in,
    input  logic [AGE_BITS-1:0]             free_age_in,
    input  logic [$clog2(MAX_SURFACES)-1:0] any_idx_in,
    input  logic [AGE_BITS-1:0]             any_age_in,
    output logic                            free_found_out,
    output logic [$clog2(MAX_SURFACES)-1:0] free_idx_out,
    output logic [AGE_BITS-1:0]             free_age_out,
    output logic [$clog2(MAX_SURFACES)-1:0] any_idx_out,
    output logic [AGE_BITS-1:0]             any_age_out
);

    localparam int IDX_W = $clog2(MAX_SURFACES);
    localparam int N_W   = $clog2(MAX_SURFACES + 1);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [spla_pkg::REF_W-1:0] ref_reg;
    logic [spla_pkg::REF_W-1:0] ref_next;
    logic [AGE_BITS-1:0]        age_reg;
    logic [AGE_BITS-1:0]        age_next;

    logic                       free_found_reg;
    logic                       free_found_next;
    logic [IDX_W-1:0]           free_idx_reg;
    logic [IDX_W-1:0]           free_idx_next;
    logic [AGE_BITS-1:0]        free_age_reg;
    logic [AGE_BITS-1:0]        free_age_next;
    logic [IDX_W-1:0]           any_idx_reg;
    logic [IDX_W-1:0]           any_idx_next;
    logic [AGE_BITS-1:0]        any_age_reg;
    logic [AGE_BITS-1:0]        any_age_next;

    logic active;
    logic hit;

    assign active = N_W'(INDEX) < count;
    assign hit    = (target == MY_IDX);

    always_comb
    begin
        ref_next = ref_reg;
        age_next = age_reg;
        unique case (op)
            spla_pkg::OP_ALLOC:
            begin
                if (hit)
                begin
                    ref_next = spla_pkg::REF_W'(1);
                    age_next = wr_age;
                end
            end
            spla_pkg::OP_RELEASE:
            begin
                if (hit && ref_reg != '0)
                    ref_next = ref_reg - spla_pkg::REF_W'(1);
            end
            spla_pkg::OP_HOLD:
            begin
                if (hit && ref_reg != spla_pkg::REF_MAX)
                    ref_next = ref_reg + spla_pkg::REF_W'(1);
            end
            spla_pkg::OP_FLUSH:
            begin
                if (active)
                    ref_next = '0;
            end
            spla_pkg::OP_CLEAR:
            begin
                ref_next = '0;
                age_next = '0;
            end
            default:
            begin
                ref_next = ref_reg;
            end
        endcase
    end

    always_comb
    begin
        free_found_next = free_found_in;
        free_idx_next   = free_idx_in;
        free_age_next   = free_age_in;
        any_idx_next    = any_idx_in;
        any_age_next    = any_age_in;
        if (active)
        begin
            if (ref_reg == '0 && (!free_found_in || age_reg < free_age_in))
            begin
                free_found_next = 1'b1;
                free_idx_next   = MY_IDX;
                free_age_next   = age_reg;
            end
            if (age_reg < any_age_in)
            begin
                any_idx_next = MY_IDX;
                any_age_next = age_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg        <= '0;
            age_reg        <= '0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            ref_reg        <= ref_next;
            age_reg        <= age_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_idx_reg <= free_idx_next;
        free_age_reg <= free_age_next;
        any_idx_reg  <= any_idx_next;
        any_age_reg  <= any_age_next;
    end

    assign free_found_out = free_found_reg;
    assign free_idx_out   = free_idx_reg;
    assign free_age_out   = free_age_reg;
    assign any_idx_out    = any_idx_reg;
    assign any_age_out    = any_age_reg;

endmodule

// ===== tb/surface_grant_checker.sv =====
`timescale 1ns / 1ps
// Checker for the surface pool allocator: watches the command, result and configuration ports,
// predicts every result beat and compares it. Depends on spla_pkg.
module surface_grant_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [spla_pkg::CMD_W-1:0]  cmd,
    input  logic [spla_pkg::SIDX_W-1:0] surface_index,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [spla_pkg::SIDX_W-1:0] granted_surface,
    input  logic                        forced_reuse,
    input  logic                        status,
    input  logic                        cfg_we,
    input  logic [spla_pkg::CFG_W-1:0]  cfg_wdata,
    output int                          errors,
    output int                          outstanding
);

    localparam int POOL_MAX = spla_pkg::DEF_MAX_SURFACES;
    localparam int AGE_W    = spla_pkg::DEF_AGE_BITS;

    typedef struct packed {
        logic [spla_pkg::SIDX_W-1:0] grant;
        logic                        forced;
        logic                        status;
    } grant_result_t;

    logic [spla_pkg::REF_W-1:0] ref_cnt [POOL_MAX];
    logic [AGE_W-1:0]           stamp [POOL_MAX];
    logic [AGE_W-1:0]           age_next;
    logic [spla_pkg::CFG_W-1:0] pool_size;
    grant_result_t              pending_grants [$];
    int unsigned                n_issued;
    int unsigned                n_retired;

    assign outstanding = int'(n_issued - n_retired);

    function automatic int live_surfaces();
        if (pool_size == 0)
            return 1;
        if (pool_size > POOL_MAX)
            return POOL_MAX;
        return int'(pool_size);
    endfunction

    function automatic grant_result_t apply_command(input logic [spla_pkg::CMD_W-1:0] c,
                                                    input logic [spla_pkg::SIDX_W-1:0] idx);
        grant_result_t r;
        int            n;
        int            oldest;
        int            free_pick;
        bit            have_free;
        int            pick;
        n = live_surfaces();
        r.grant = idx;
        r.forced = 1'b0;
        r.status = 1'b0;
        oldest = 0;
        free_pick = 0;
        have_free = 1'b0;
        case (c)
            spla_pkg::CMD_ALLOC:
            begin
                for (int i = 0; i < n; i++)
                begin
                    if (ref_cnt[i] == 0 && (!have_free || stamp[i] < stamp[free_pick]))
                    begin
                        free_pick = i;
                        have_free = 1'b1;
                    end
                    if (stamp[i] < stamp[oldest])
                        oldest = i;
                end
                if (have_free)
                    pick = free_pick;
                else
                begin
                    pick = oldest;
                    r.forced = 1'b1;
                end
                stamp[pick] = age_next;
                if (age_next != '1)
                    age_next = age_next + AGE_W'(1);
                ref_cnt[pick] = spla_pkg::REF_W'(1);
                r.grant = spla_pkg::SIDX_W'(pick);
            end
            spla_pkg::CMD_RELEASE, spla_pkg::CMD_HOLD:
            begin
                if (int'(idx) >= n)
                    r.status = 1'b1;
                else if (c == spla_pkg::CMD_RELEASE)
                begin
                    if (ref_cnt[idx] != 0)
                        ref_cnt[idx] = ref_cnt[idx] - spla_pkg::REF_W'(1);
                end
                else if (ref_cnt[idx] != spla_pkg::REF_MAX)
                    ref_cnt[idx] = ref_cnt[idx] + spla_pkg::REF_W'(1);
            end
            spla_pkg::CMD_FLUSH:
            begin
                for (int i = 0; i < n; i++)
                    ref_cnt[i] = '0;
            end
            spla_pkg::CMD_RESET:
            begin
                for (int i = 0; i < POOL_MAX; i++)
                begin
                    ref_cnt[i] = '0;
                    stamp[i] = '0;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t ns: %s is %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grant_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_MAX; i++)
            begin
                ref_cnt[i] = '0;
                stamp[i] = '0;
            end
            age_next = AGE_W'(1);
            pool_size = spla_pkg::CFG_RESET;
            pending_grants.delete();
            errors = 0;
            n_issued <= 0;
            n_retired <= 0;
        end
        else
        begin
            if (cfg_we)
                pool_size = cfg_wdata;
            if (in_valid && in_ready)
            begin
                pending_grants.push_back(apply_command(cmd, surface_index));
                n_issued <= n_issued + 1;
            end
            if (out_valid && out_ready)
            begin
                if (pending_grants.size() == 0)
                    report_mismatch("unexpected result beat, granted_surface",
                                    granted_surface, 0);
                else
                begin
                    want = pending_grants.pop_front();
                    n_retired <= n_retired + 1;
                    if (granted_surface !== want.grant)
                        report_mismatch("granted_surface", granted_surface, want.grant);
                    if (forced_reuse !== want.forced)
                        report_mismatch("forced_reuse", forced_reuse, want.forced);
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                end
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the surface pool allocator testbench: clock, reset, command and result traffic,
// configuration phases and the verdict. Depends on spla_pkg, surface_grant_checker and the block.
module testbench;

    localparam logic [spla_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [spla_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam int PHASES          = 12;
    localparam int BEATS_PER_PHASE = 128;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 400000;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [spla_pkg::CMD_W-1:0]  cmd;
    logic [spla_pkg::SIDX_W-1:0] surface_index;
    logic                        out_valid;
    logic                        out_ready;
    logic [spla_pkg::SIDX_W-1:0] granted_surface;
    logic                        forced_reuse;
    logic                        status;
    logic                        cfg_we;
    logic [spla_pkg::CFG_W-1:0]  cfg_wdata;
    int                          errors;
    int                          outstanding;
    int                          cycles;
    int                          pool_cfg;
    bit                          hold_off_req;
    bit                          calm;

    surface_pool_lru_allocator dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .surface_index   (surface_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .granted_surface (granted_surface),
        .forced_reuse    (forced_reuse),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata)
    );

    surface_grant_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .surface_index   (surface_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .granted_surface (granted_surface),
        .forced_reuse    (forced_reuse),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .errors          (errors),
        .outstanding     (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("surface_pool_lru_allocator verification failed");
        $finish;
    end

    // The result side stalls in short random bursts, once for a long stretch on request,
    // and not at all once the run turns calm.
    initial
    begin
        bit hold_off_done;
        hold_off_done = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req && !hold_off_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 99) < 25)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    task automatic push_beat(input logic [spla_pkg::CMD_W-1:0] c,
                             input logic [spla_pkg::SIDX_W-1:0] idx);
        in_valid <= 1'b1;
        cmd <= c;
        surface_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic take_gap();
        if (!calm && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic issue(input logic [spla_pkg::CMD_W-1:0] c,
                         input logic [spla_pkg::SIDX_W-1:0] idx);
        push_beat(c, idx);
        take_gap();
    endtask

    task automatic write_pool_size(input int value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= spla_pkg::CFG_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        pool_cfg = value;
    endtask

    task automatic random_beat();
        int                          n_eff;
        int                          pick;
        logic [spla_pkg::SIDX_W-1:0] idx;
        n_eff = (pool_cfg == 0) ? 1
              : (pool_cfg > spla_pkg::DEF_MAX_SURFACES) ? spla_pkg::DEF_MAX_SURFACES
              : pool_cfg;
        idx = ($urandom_range(0, 99) < 85) ? spla_pkg::SIDX_W'($urandom_range(0, n_eff - 1))
                                           : spla_pkg::SIDX_W'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        if (pick < 45)
            issue(spla_pkg::CMD_ALLOC, spla_pkg::SIDX_W'($urandom_range(0, 31)));
        else if (pick < 65)
            issue(spla_pkg::CMD_RELEASE, idx);
        else if (pick < 83)
            issue(spla_pkg::CMD_HOLD, idx);
        else if (pick < 87)
            issue(spla_pkg::CMD_FLUSH, spla_pkg::SIDX_W'($urandom_range(0, 31)));
        else if (pick < 90)
            issue(spla_pkg::CMD_RESET, spla_pkg::SIDX_W'($urandom_range(0, 31)));
        else if (pick < 93)
            issue(spla_pkg::CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                  spla_pkg::SIDX_W'($urandom_range(0, 31)));
        else
            issue(spla_pkg::CMD_W'($urandom_range(spla_pkg::CMD_ALLOC, CMD_SPARE_HI)),
                  spla_pkg::SIDX_W'($urandom_range(0, 31)));
    endtask

    initial
    begin
        int phase_size [PHASES];
        phase_size = '{32, 1, 4, 63, 0, 2, 33, 16, 0, 3, 32, 0};
        phase_size[8] = $urandom_range(1, 32);
        phase_size[11] = $urandom_range(0, 63);
        hold_off_req <= 1'b0;
        calm <= 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        cmd <= spla_pkg::CMD_ALLOC;
        surface_index <= '0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        pool_cfg = spla_pkg::CFG_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Two-surface pool: ties to the lowest index, forced reuse, out-of-range index,
        // release at zero, hold saturation, flush, pool reset and spare command codes.
        write_pool_size(2);
        issue(spla_pkg::CMD_ALLOC, '0);
        issue(spla_pkg::CMD_ALLOC, '1);
        issue(spla_pkg::CMD_ALLOC, '0);
        issue(spla_pkg::CMD_RELEASE, 5'd31);
        issue(spla_pkg::CMD_RELEASE, 5'd1);
        issue(spla_pkg::CMD_RELEASE, 5'd1);
        repeat (15) issue(spla_pkg::CMD_HOLD, 5'd0);
        issue(spla_pkg::CMD_FLUSH, 5'd31);
        issue(spla_pkg::CMD_RESET, 5'd0);
        issue(CMD_SPARE_LO, 5'd31);
        issue(CMD_SPARE_HI, 5'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            write_pool_size(phase_size[p]);
            if (p == 3)
                hold_off_req <= 1'b1;
            if (p == PHASES - 1)
                calm <= 1'b1;
            repeat (BEATS_PER_PHASE) random_beat();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (3 * spla_pkg::DEF_MAX_SURFACES) @(posedge clk);
        if (errors == 0)
            $display("surface_pool_lru_allocator verification clean");
        else
            $display("surface_pool_lru_allocator verification failed");
        $finish;
    end

endmodule
